@@ rtl/core/u2j_pkg.sv @@
// Package for the UTF-8 to JSON string escaper.
// Holds request, response and job types, character constants and helpers.
// No dependencies.
package u2j_pkg;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOW_B  = 8'h62;
  localparam logic [7:0] CHAR_LOW_F  = 8'h66;
  localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
  localparam logic [7:0] CHAR_LOW_R  = 8'h72;
  localparam logic [7:0] CHAR_LOW_T  = 8'h74;
  localparam logic [7:0] CHAR_LOW_U  = 8'h75;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_BS     = 8'h08;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_FF     = 8'h0C;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam logic [15:0] UNIT_CTRL_LIMIT = 16'h0020;
  localparam logic [15:0] UNIT_HIGH_START = 16'h0080;

  localparam logic [20:0] CP_MIN_TWO   = 21'h000080;
  localparam logic [20:0] CP_MIN_THREE = 21'h000800;
  localparam logic [20:0] CP_MIN_FOUR  = 21'h010000;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

  // character positions inside one unit
  localparam logic [2:0] POS_FIRST  = 3'd0;
  localparam logic [2:0] POS_SECOND = 3'd1;
  localparam logic [2:0] POS_HEX3   = 3'd2;
  localparam logic [2:0] POS_HEX2   = 3'd3;
  localparam logic [2:0] POS_HEX1   = 3'd4;
  localparam logic [2:0] POS_HEX0   = 3'd5;

  typedef enum logic [1:0] {
    UK_PLAIN,
    UK_SHORT,
    UK_HEX
  } unit_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       string_done;
    logic       bad_input;
  } out_rsp_t;

  typedef struct packed {
    logic        bad;
    logic        str_end;
    logic        two_units;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } job_t;

  function automatic logic [7:0] short_letter(logic [15:0] unit);
    logic [7:0] letter;
    letter = CHAR_NUL;
    case (unit)
      {8'h00, CHAR_QUOTE}:  letter = CHAR_QUOTE;
      {8'h00, CHAR_BSLASH}: letter = CHAR_BSLASH;
      {8'h00, CHAR_BS}:     letter = CHAR_LOW_B;
      {8'h00, CHAR_FF}:     letter = CHAR_LOW_F;
      {8'h00, CHAR_LF}:     letter = CHAR_LOW_N;
      {8'h00, CHAR_CR}:     letter = CHAR_LOW_R;
      {8'h00, CHAR_TAB}:    letter = CHAR_LOW_T;
      default:              letter = CHAR_NUL;
    endcase
    return letter;
  endfunction

  function automatic unit_kind_e unit_kind(logic [15:0] unit);
    unit_kind_e kind;
    if (short_letter(unit) != CHAR_NUL) begin
      kind = UK_SHORT;
    end else if (unit < UNIT_CTRL_LIMIT || unit >= UNIT_HIGH_START) begin
      kind = UK_HEX;
    end else begin
      kind = UK_PLAIN;
    end
    return kind;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'h0, nib};
    end else begin
      c = CHAR_LOW_A + {4'h0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/utf8_to_json_string_escaper.sv @@
// UTF-8 to JSON string escaper, top level. Takes one UTF-8 byte per request and
// emits escaped JSON characters one per cycle unless out_ready_i stalls the output;
// a plain ASCII byte then passes at one byte per cycle, while a byte completing an
// escaped code point holds the input while the job register sends each character
// it yields (2 for a short escape, 6 per \u unit, up to 12 for a surrogate pair)
// through the single output register. Depends on u2j_pkg, u2j_decode, u2j_emit.
module utf8_to_json_string_escaper (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  u2j_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u2j_pkg::out_rsp_t out_rsp_o
);
  import u2j_pkg::*;

  logic accept;
  job_t job;
  logic has_job;
  logic job_ready;

  assign in_ready_o = job_ready;
  assign accept     = in_valid_i && job_ready;

  u2j_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (in_req_i),
    .job_o     (job),
    .has_job_o (has_job)
  );

  u2j_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (accept && has_job),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ rtl/core/u2j_decode.sv @@
// UTF-8 decoder for the JSON string escaper.
// Keeps sequence state and turns each code point into a job of UTF-16 units.
// Depends on u2j_pkg.
module u2j_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  u2j_pkg::in_req_t req_i,
  output u2j_pkg::job_t    job_o,
  output logic             has_job_o
);
  import u2j_pkg::*;

  logic [20:0] acc_q, acc_d;
  logic [1:0]  left_q, left_d;
  logic [1:0]  seq_q, seq_d;

  logic [7:0]  b;
  logic [20:0] cp;
  logic [20:0] min_cp;
  logic [19:0] v;
  logic        emit_cp;
  logic [20:0] emit_val;
  logic        bad;

  assign b  = req_i.in_byte;
  assign cp = {acc_q[14:0], b[5:0]};
  assign v  = 20'(emit_val - CP_MIN_FOUR);

  always_comb begin
    acc_d    = acc_q;
    left_d   = left_q;
    seq_d    = seq_q;
    emit_cp  = 1'b0;
    emit_val = {13'h0, b};
    bad      = 1'b0;
    case (seq_q)
      2'd1:    min_cp = CP_MIN_TWO;
      2'd2:    min_cp = CP_MIN_THREE;
      default: min_cp = CP_MIN_FOUR;
    endcase
    if (left_q == 2'd0) begin
      if (b[7] == 1'b0) begin
        emit_cp = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        acc_d  = {16'h0, b[4:0]};
        left_d = 2'd1;
        seq_d  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_d  = {17'h0, b[3:0]};
        left_d = 2'd2;
        seq_d  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_d  = {18'h0, b[2:0]};
        left_d = 2'd3;
        seq_d  = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      acc_d  = cp;
      left_d = left_q - 2'd1;
      if (left_q == 2'd1) begin
        acc_d = '0;
        seq_d = 2'd0;
        if (cp < min_cp || (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp > CP_MAX) begin
          bad = 1'b1;
        end else begin
          emit_cp  = 1'b1;
          emit_val = cp;
        end
      end
    end
    if (req_i.string_end && left_d != 2'd0) begin
      bad = 1'b1;
    end
    if (bad) begin
      acc_d   = '0;
      left_d  = 2'd0;
      seq_d   = 2'd0;
      emit_cp = 1'b0;
    end
  end

  always_comb begin
    job_o.bad     = bad;
    job_o.str_end = req_i.string_end;
    if (emit_val >= CP_MIN_FOUR) begin
      job_o.two_units = 1'b1;
      job_o.unit0     = {SURR_HIGH_TAG, v[19:10]};
      job_o.unit1     = {SURR_LOW_TAG, v[9:0]};
    end else begin
      job_o.two_units = 1'b0;
      job_o.unit0     = emit_val[15:0];
      job_o.unit1     = emit_val[15:0];
    end
  end

  assign has_job_o = bad || emit_cp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= 2'd0;
      seq_q  <= 2'd0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      left_q <= left_d;
      seq_q  <= seq_d;
    end
  end

endmodule

@@ rtl/core/u2j_emit.sv @@
// Escape emitter for the JSON string escaper.
// Holds one job, walks its characters and drives the output register.
// Depends on u2j_pkg.
module u2j_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  u2j_pkg::job_t     job_i,
  output logic              job_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u2j_pkg::out_rsp_t out_rsp_o
);
  import u2j_pkg::*;

  logic       job_valid_q;
  job_t       job_q;
  logic       uidx_q;
  logic [2:0] cidx_q;
  logic       out_valid_q;
  out_rsp_t   out_q;

  logic [15:0] cur_unit;
  unit_kind_e  kind;
  logic        out_free;
  logic        step;
  logic        unit_done;
  logic        job_done;
  logic        load;
  logic [7:0]  ch;

  assign cur_unit = uidx_q ? job_q.unit1 : job_q.unit0;
  assign kind     = unit_kind(cur_unit);
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = job_valid_q && out_free;

  always_comb begin
    case (kind)
      UK_PLAIN: unit_done = (cidx_q == POS_FIRST);
      UK_SHORT: unit_done = (cidx_q == POS_SECOND);
      default:  unit_done = (cidx_q == POS_HEX0);
    endcase
    job_done = job_q.bad || (unit_done && (uidx_q == job_q.two_units));
    case (cidx_q)
      POS_FIRST:  ch = (kind == UK_PLAIN) ? cur_unit[7:0] : CHAR_BSLASH;
      POS_SECOND: ch = (kind == UK_SHORT) ? short_letter(cur_unit) : CHAR_LOW_U;
      POS_HEX3:   ch = hex_char(cur_unit[15:12]);
      POS_HEX2:   ch = hex_char(cur_unit[11:8]);
      POS_HEX1:   ch = hex_char(cur_unit[7:4]);
      POS_HEX0:   ch = hex_char(cur_unit[3:0]);
      default:    ch = CHAR_NUL;
    endcase
    if (job_q.bad) begin
      ch = CHAR_NUL;
    end
  end

  assign job_ready_o = !job_valid_q || (step && job_done);
  assign load        = job_valid_i && job_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      uidx_q      <= 1'b0;
      cidx_q      <= POS_FIRST;
    end else if (load) begin
      job_valid_q <= 1'b1;
      uidx_q      <= 1'b0;
      cidx_q      <= POS_FIRST;
    end else if (step && job_done) begin
      job_valid_q <= 1'b0;
    end else if (step) begin
      if (unit_done) begin
        uidx_q <= 1'b1;
        cidx_q <= POS_FIRST;
      end else begin
        cidx_q <= cidx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (step) begin
      out_q.out_char    <= ch;
      out_q.run_last    <= job_done;
      out_q.string_done <= job_done && job_q.str_end;
      out_q.bad_input   <= job_q.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
